@@ rtl/qkr_pkg.sv @@
// ----------------------------------------------------------------------------
// qkr_pkg
// Shared sizes, types, codes and helpers for the keyed-removal queue.
// ----------------------------------------------------------------------------
`default_nettype none

package qkr_pkg;

	localparam int DEPTH    = 16;
	localparam int KEY_BITS = 32;

	localparam int PORT_KEY_BITS = 32;
	localparam int OCC_BITS      = 5;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef logic [KEY_BITS-1:0]      key_t;
	typedef logic [PTR_W-1:0]         ptr_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic [PORT_KEY_BITS-1:0] port_key_t;
	typedef logic [OCC_BITS-1:0]      occ_t;

	typedef enum logic [1:0] {
		CMD_ENQUEUE = 2'd0,
		CMD_REMOVE  = 2'd1,
		CMD_SERVE   = 2'd2,
		CMD_INVALID = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_ADDED     = 3'd0,
		ST_FULL      = 3'd1,
		ST_REMOVED   = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_EMPTY     = 3'd4,
		ST_SERVED    = 3'd5,
		ST_INVALID   = 3'd6
	} status_t;

	typedef struct packed {
		logic we;
		ptr_t waddr;
		key_t wdata;
		logic re;
		ptr_t raddr;
	} ram_req_t;

	function automatic key_t to_key(input port_key_t x);
		key_t k;
		k = '0;
		for (int i = 0; i < KEY_BITS; i++) begin
			if (i < PORT_KEY_BITS) begin
				k[i] = x[i];
			end
		end
		return k;
	endfunction

	function automatic port_key_t from_key(input key_t k);
		port_key_t x;
		x = '0;
		for (int i = 0; i < PORT_KEY_BITS; i++) begin
			if (i < KEY_BITS) begin
				x[i] = k[i];
			end
		end
		return x;
	endfunction

	function automatic occ_t to_occ(input cnt_t c);
		occ_t o;
		o = '0;
		for (int i = 0; i < OCC_BITS; i++) begin
			if (i < CNT_W) begin
				o[i] = c[i];
			end
		end
		return o;
	endfunction

	function automatic ptr_t ptr_next(input ptr_t p);
		ptr_t n;
		if (p == PTR_W'(DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + 1'b1;
		end
		return n;
	endfunction

endpackage

`default_nettype wire

@@ rtl/qkr_ram.sv @@
// ----------------------------------------------------------------------------
// qkr_ram
// Entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module qkr_ram
	import qkr_pkg::*;
(
	input  wire logic     clk,
	input  wire ram_req_t req,
	output key_t          rdata
);

	key_t mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/queue_with_keyed_removal.sv @@
// ----------------------------------------------------------------------------
// queue_with_keyed_removal
// Bounded FIFO of key tags with enqueue, remove-by-key and serve commands.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry command and key. Output channel:
// out_valid / out_stall carry status, result_key and occupancy. A transaction
// moves on a rising edge with valid high and stall low; one result per command.
// Entries live in a circular buffer in a single-port-read RAM, so serve only
// advances the head. Remove-by-key scans from the head one entry per cycle,
// then shifts younger entries one slot toward the head, one per cycle.
// From input to output transaction, each command passes S_EXEC and then
// S_FINISH; serve adds S_SERVE, and remove on a non-empty queue adds S_SCAN,
// plus S_SHIFT on a match; at most one RAM read per cycle.
// One command is in work at a time: in_stall is high from acceptance until
// the result is loaded into the output register, so commands are spaced by
// the latency. A result waiting on out_stall holds the output register; the
// next command may be accepted, but its result is not loaded until the
// waiting one is taken.
// Reset (arst_n low) empties the queue; RAM contents need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module queue_with_keyed_removal
	import qkr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,

	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] command,
	input  wire port_key_t  key,

	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [2:0]      status,
	output port_key_t       result_key,
	output occ_t            occupancy
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SERVE,
		S_SCAN,
		S_SHIFT,
		S_FINISH
	} state_t;

	state_t    state_q;
	cmd_t      cmd_q;
	key_t      key_q;
	ptr_t      head_q;
	ptr_t      tail_q;
	cnt_t      count_q;
	cnt_t      off_q;
	ptr_t      ptr_q;
	ptr_t      wptr_q;
	cnt_t      rem_q;
	logic      vld_s1;
	cnt_t      off_s1;
	ptr_t      ptr_s1;
	status_t   res_status_q;
	port_key_t res_key_q;
	logic      out_valid_q;

	ram_req_t  req;
	key_t      rdata;
	logic      full;
	logic      empty;
	logic      hit;
	logic      scan_issue;
	logic      shift_issue;
	logic      out_free;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign hit      = vld_s1 && (rdata == key_q);
	assign out_free = !out_valid_q || !out_stall;

	assign scan_issue  = (state_q == S_SCAN) && !hit && (off_q < count_q);
	assign shift_issue = (state_q == S_SHIFT) && (rem_q != '0);

	always_comb begin
		req       = '0;
		req.wdata = key_q;
		req.waddr = wptr_q;
		req.raddr = ptr_q;
		case (state_q)
			S_EXEC: begin
				if (cmd_q == CMD_ENQUEUE && !full) begin
					req.we    = 1'b1;
					req.waddr = tail_q;
				end
				if (cmd_q == CMD_SERVE && !empty) begin
					req.re    = 1'b1;
					req.raddr = head_q;
				end
			end
			S_SCAN: begin
				req.re = scan_issue;
			end
			S_SHIFT: begin
				req.re    = shift_issue;
				req.we    = vld_s1;
				req.wdata = rdata;
			end
			default: begin
			end
		endcase
	end

	qkr_ram u_ram (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			vld_s1       <= 1'b0;
			out_valid_q  <= 1'b0;
			cmd_q        <= CMD_INVALID;
			res_status_q <= ST_INVALID;
			key_q        <= '0;
			off_q        <= '0;
			ptr_q        <= '0;
			wptr_q       <= '0;
			rem_q        <= '0;
			off_s1       <= '0;
			ptr_s1       <= '0;
			res_key_q    <= '0;
			status       <= '0;
			result_key   <= '0;
			occupancy    <= '0;
		end else begin
			if (state_q == S_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q   <= cmd_t'(command);
						key_q   <= to_key(key);
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_key_q <= '0;
					state_q   <= S_FINISH;
					case (cmd_q)
						CMD_ENQUEUE: begin
							if (full) begin
								res_status_q <= ST_FULL;
							end else begin
								tail_q       <= ptr_next(tail_q);
								count_q      <= count_q + 1'b1;
								res_status_q <= ST_ADDED;
								res_key_q    <= from_key(key_q);
							end
						end
						CMD_REMOVE: begin
							if (empty) begin
								res_status_q <= ST_EMPTY;
							end else begin
								off_q   <= '0;
								ptr_q   <= head_q;
								vld_s1  <= 1'b0;
								state_q <= S_SCAN;
							end
						end
						CMD_SERVE: begin
							if (empty) begin
								res_status_q <= ST_EMPTY;
							end else begin
								state_q <= S_SERVE;
							end
						end
						default: begin
							res_status_q <= ST_INVALID;
						end
					endcase
				end
				S_SERVE: begin
					res_status_q <= ST_SERVED;
					res_key_q    <= from_key(rdata);
					head_q       <= ptr_next(head_q);
					count_q      <= count_q - 1'b1;
					state_q      <= S_FINISH;
				end
				S_SCAN: begin
					vld_s1 <= scan_issue;
					if (scan_issue) begin
						off_s1 <= off_q;
						ptr_s1 <= ptr_q;
						off_q  <= off_q + 1'b1;
						ptr_q  <= ptr_next(ptr_q);
					end
					if (hit) begin
						wptr_q  <= ptr_s1;
						ptr_q   <= ptr_next(ptr_s1);
						rem_q   <= count_q - 1'b1 - off_s1;
						state_q <= S_SHIFT;
					end else if (!vld_s1 && !scan_issue) begin
						res_status_q <= ST_NOT_FOUND;
						res_key_q    <= '0;
						state_q      <= S_FINISH;
					end
				end
				S_SHIFT: begin
					vld_s1 <= shift_issue;
					if (shift_issue) begin
						ptr_q <= ptr_next(ptr_q);
						rem_q <= rem_q - 1'b1;
					end
					if (vld_s1) begin
						wptr_q <= ptr_next(wptr_q);
					end
					if (!vld_s1 && !shift_issue) begin
						tail_q       <= wptr_q;
						count_q      <= count_q - 1'b1;
						res_status_q <= ST_REMOVED;
						res_key_q    <= from_key(key_q);
						state_q      <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						status      <= res_status_q;
						result_key  <= res_key_q;
						occupancy   <= to_occ(count_q);
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire
